>>> rtl/core/tkfs_pkg.sv
// Shared types and constants for the top-k flow selection unit.
`timescale 1ns / 1ps

package tkfs_pkg;

    localparam int ID_W   = 32;
    localparam int FLOW_W = 24;
    localparam int RANK_W = 5;
    localparam int CFG_W  = 6;

    localparam int unsigned DEFAULT_DEPTH = 32;
    localparam logic [CFG_W-1:0] MAX_SELECT_RESET = 6'd32;

    typedef struct packed {
        logic [ID_W-1:0]   candidate_id;
        logic              flow_known;
        logic [FLOW_W-1:0] flow_value;
        logic              set_end;
    } t_cand;

    typedef struct packed {
        logic [ID_W-1:0]   chosen_id;
        logic [FLOW_W-1:0] chosen_flow;
        logic [RANK_W-1:0] rank;
        logic              run_last;
        logic              none_chosen;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic size;
        logic emit;
        logic emit_empty;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic sel_zero;
        logic last_one;
    } t_status;

endpackage

>>> rtl/core/tkfs_ctrl.sv
// Controller state machine: collect candidates, size the set, drain results.
`timescale 1ns / 1ps

module tkfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_set_end,
    input  tkfs_pkg::t_status i_status,
    output logic             o_in_ready,
    output tkfs_pkg::t_cmd   o_cmd
);
    import tkfs_pkg::*;

    typedef enum logic [1:0] {
        S_TAKE,
        S_SIZE,
        S_EMIT,
        S_EMPTY
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_TAKE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_set_end) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
                n_state = i_status.sel_zero ? S_EMPTY : S_EMIT;
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_one) begin
                        n_state = S_TAKE;
                    end
                end
            end
            S_EMPTY: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state = S_TAKE;
                end
            end
            default: begin
                n_state = S_TAKE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_TAKE;
            o_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            o_in_ready <= (n_state == S_TAKE);
        end
    end

endmodule

>>> rtl/core/tkfs_datapath.sv
// Datapath: sorted insertion table, limit register, drain counters and output register.
`timescale 1ns / 1ps

module tkfs_datapath #(
    parameter int unsigned TABLE_DEPTH = tkfs_pkg::DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tkfs_pkg::t_cmd             i_cmd,
    input  tkfs_pkg::t_cand            i_cand,
    input  logic                       i_cfg_wr_en,
    input  logic [tkfs_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                       i_out_ready,
    output tkfs_pkg::t_status          o_status,
    output logic                       o_out_valid,
    output tkfs_pkg::t_result          o_out_data
);
    import tkfs_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]  r_max_select;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    logic [RANK_W-1:0] r_rank;
    logic [ID_W-1:0]   r_ids   [TABLE_DEPTH];
    logic [FLOW_W-1:0] r_flows [TABLE_DEPTH];
    logic              r_out_valid;
    t_result           r_out_data;

    logic [CNT_W-1:0]       w_limit;
    logic                   w_grow;
    logic [CNT_W-1:0]       w_bound;
    logic [TABLE_DEPTH-1:0] w_ahead;
    logic [TABLE_DEPTH-1:0] w_prev_ahead;
    logic [TABLE_DEPTH-1:0] w_room;
    logic                   w_insert;
    logic [ID_W-1:0]        w_prev_id   [TABLE_DEPTH];
    logic [FLOW_W-1:0]      w_prev_flow [TABLE_DEPTH];
    logic [ID_W-1:0]        w_next_id   [TABLE_DEPTH];
    logic [FLOW_W-1:0]      w_next_flow [TABLE_DEPTH];

    // A limit above the table depth acts as the depth.
    always_comb begin
        if (CMP_W'(r_max_select) > CMP_W'(TABLE_DEPTH)) begin
            w_limit = CNT_W'(TABLE_DEPTH);
        end else begin
            w_limit = CNT_W'(r_max_select);
        end
    end

    assign w_grow  = (r_count < w_limit);
    assign w_bound = w_grow ? (r_count + CNT_W'(1)) : r_count;

    // An entry stays ahead of the newcomer when it is valid and its flow is not lower.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_ahead[i] = (CNT_W'(i) < r_count) && (r_flows[i] >= i_cand.flow_value);
            w_room[i]  = !w_ahead[i] && (CNT_W'(i) < w_limit);
        end
    end

    assign w_insert = i_cmd.take && i_cand.flow_known && (|w_room);

    // Neighbor taps for the insertion shift and the drain shift.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_tap
        if (g == 0) begin : g_head
            assign w_prev_ahead[g] = 1'b1;
            assign w_prev_id[g]    = i_cand.candidate_id;
            assign w_prev_flow[g]  = i_cand.flow_value;
        end else begin : g_body
            assign w_prev_ahead[g] = w_ahead[g-1];
            assign w_prev_id[g]    = r_ids[g-1];
            assign w_prev_flow[g]  = r_flows[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next_id[g]   = r_ids[g];
            assign w_next_flow[g] = r_flows[g];
        end else begin : g_inner
            assign w_next_id[g]   = r_ids[g+1];
            assign w_next_flow[g] = r_flows[g+1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_insert && !w_ahead[i]) begin
                if (w_prev_ahead[i]) begin
                    r_ids[i]   <= i_cand.candidate_id;
                    r_flows[i] <= i_cand.flow_value;
                end else if (CNT_W'(i) < w_bound) begin
                    r_ids[i]   <= w_prev_id[i];
                    r_flows[i] <= w_prev_flow[i];
                end
            end else if (i_cmd.emit) begin
                r_ids[i]   <= w_next_id[i];
                r_flows[i] <= w_next_flow[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_select <= MAX_SELECT_RESET;
            r_count      <= '0;
            r_left       <= '0;
            r_rank       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_select <= i_cfg_wr_data;
            end
            if (i_cmd.size) begin
                r_count <= '0;
                r_left  <= w_grow ? r_count : w_limit;
                r_rank  <= '0;
            end else begin
                if (w_insert && w_grow) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_cmd.emit) begin
                    r_left <= r_left - CNT_W'(1);
                    r_rank <= r_rank + RANK_W'(1);
                end
            end
            if (i_cmd.emit || i_cmd.emit_empty) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.chosen_id   <= r_ids[0];
            r_out_data.chosen_flow <= r_flows[0];
            r_out_data.rank        <= r_rank;
            r_out_data.run_last    <= (r_left == CNT_W'(1));
            r_out_data.none_chosen <= 1'b0;
        end else if (i_cmd.emit_empty) begin
            r_out_data.chosen_id   <= '0;
            r_out_data.chosen_flow <= '0;
            r_out_data.rank        <= '0;
            r_out_data.run_last    <= 1'b1;
            r_out_data.none_chosen <= 1'b1;
        end
    end

    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.sel_zero  = (r_count == '0) || (w_limit == '0);
    assign o_status.last_one  = (r_left == CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/core/top_k_by_flow_select_unit.sv
// Top level of the top-k flow selection unit: controller, datapath and checks.
//
//   Channel   Direction  Signals                             Moves
//   in        sink       i_in_valid/o_in_ready/i_in_data     one candidate
//   out       source     o_out_valid/i_out_ready/o_out_data  one ranked result
//   cfg       sink       i_cfg_wr_en/i_cfg_wr_data           max_select register
//
// While a set is collected, one candidate is taken every cycle; the parallel
// compare-and-shift table inserts it in the same cycle.
// After the set_end transfer the input stalls while the set is sized and its kept
// results (or the one empty result) are loaded into the output register.
// The output register holds one result; a stalled output stalls the drain only.
// Reset is synchronous and active low; table contents need no clearing, and
// max_select returns to 32.
`timescale 1ns / 1ps

module top_k_by_flow_select_unit #(
    parameter int unsigned TABLE_DEPTH = tkfs_pkg::DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tkfs_pkg::t_cand            i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tkfs_pkg::t_result          o_out_data,
    input  logic                       i_cfg_wr_en,
    input  logic [tkfs_pkg::CFG_W-1:0] i_cfg_wr_data
);
    import tkfs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tkfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_set_end  (i_in_data.set_end),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    tkfs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cand        (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (i_out_ready),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    // At most one datapath command is issued in any cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

    // The transfer that closes a set stops intake until the set has drained.
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.set_end) |=> !o_in_ready)
        else $error("input still ready after set end");

    // An empty set result is always the single, final result of its set.
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.none_chosen) |->
            (o_out_data.run_last && (o_out_data.rank == '0)))
        else $error("empty result is not a lone final result");

    // A result is only loaded while intake is stopped.
    a_drain_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit || w_cmd.emit_empty) |-> !o_in_ready)
        else $error("result loaded while input is open");

endmodule

>>> tb/top_k_by_flow_select_unit_tb.sv
// Self-checking testbench for the top-k flow selection unit with a built-in ranking predictor.
`timescale 1ns / 1ps

module top_k_by_flow_select_unit_tb;
    import tkfs_pkg::*;

    localparam int DEPTH           = DEFAULT_DEPTH;
    localparam int DIR_ROWS        = 28;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam t_result NO_RES    = '0;
    localparam t_result EMPTY_RES = '{32'd0, 24'd0, 5'd0, 1'b1, 1'b1};

    typedef enum logic {ROW_CAND, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] limit;
        t_cand            cand;
        logic             typed;
        t_result          res;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_cand            i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_result          o_out_data;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    // Sideband that travels with the candidate currently offered.
    logic    row_typed;
    t_result row_res;

    // Predictor state: the sorted table of kept candidates and the limit copy.
    logic [ID_W-1:0]   held_ids   [DEPTH];
    logic [FLOW_W-1:0] held_flows [DEPTH];
    int                held_num   = 0;
    int                limit_copy = 32;
    t_result           ranked_q[$];
    t_result           want;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int num_errors    = 0;
    int num_checked   = 0;
    int num_empty     = 0;
    int num_cands     = 0;
    int num_sets      = 0;

    t_row dir_rows [DIR_ROWS];

    top_k_by_flow_select_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Inserts one candidate into the predicted table and, on the set end, queues the
    // ranked results. A typed result from the stimulus table replaces the computed ones.
    function automatic void rank_candidate(t_cand c, logic use_typed, t_result typed_res);
        int      eff;
        int      pos;
        int      n;
        t_result r;
        eff = (limit_copy > DEPTH) ? DEPTH : limit_copy;
        if (c.flow_known) begin
            pos = 0;
            while (pos < held_num && held_flows[pos] >= c.flow_value) pos++;
            if (pos < eff) begin
                if (held_num < eff) held_num++;
                for (int i = held_num - 1; i > pos; i--) begin
                    held_ids[i]   = held_ids[i-1];
                    held_flows[i] = held_flows[i-1];
                end
                held_ids[pos]   = c.candidate_id;
                held_flows[pos] = c.flow_value;
            end
        end
        if (c.set_end) begin
            n = (held_num > eff) ? eff : held_num;
            num_sets++;
            if (use_typed) begin
                ranked_q.insert(ranked_q.size(), typed_res);
            end else if (n == 0) begin
                ranked_q.insert(ranked_q.size(), EMPTY_RES);
            end else begin
                for (int k = 0; k < n; k++) begin
                    r.chosen_id   = held_ids[k];
                    r.chosen_flow = held_flows[k];
                    r.rank        = RANK_W'(k);
                    r.run_last    = (k == n - 1);
                    r.none_chosen = 1'b0;
                    ranked_q.insert(ranked_q.size(), r);
                end
            end
            held_num = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            num_errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Predictor and scoreboard, both driven from what the block accepts at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) limit_copy = int'(i_cfg_wr_data);
            if (i_in_valid && o_in_ready) begin
                num_cands++;
                rank_candidate(i_in_data, row_typed, row_res);
            end
            if (o_out_valid && i_out_ready) begin
                if (ranked_q.size() == 0) begin
                    num_errors++;
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, o_out_data);
                end else begin
                    want = ranked_q.pop_front();
                    check_field("chosen_id", want.chosen_id, o_out_data.chosen_id);
                    check_field("chosen_flow", 32'(want.chosen_flow),
                                32'(o_out_data.chosen_flow));
                    check_field("rank", 32'(want.rank), 32'(o_out_data.rank));
                    check_field("run_last", 32'(want.run_last), 32'(o_out_data.run_last));
                    check_field("none_chosen", 32'(want.none_chosen),
                                32'(o_out_data.none_chosen));
                    num_checked++;
                    if (want.none_chosen) num_empty++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the block backs up.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_cand(input t_cand c, input logic typed, input t_result res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        row_typed  <= typed;
        row_res    <= res;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // The limit only changes once every queued result has drained and the block settled.
    task automatic write_limit(input logic [CFG_W-1:0] lim);
        i_in_valid <= 1'b0;
        while (ranked_q.size() != 0 || o_out_valid) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lim;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] lim, input int s_pct, input int r_pct,
                             input bit pressure);
        int    sent;
        int    len;
        bit    blank;
        t_cand c;
        write_limit(lim);
        send_idle_pct = s_pct;
        stall_pct     = r_pct;
        if (pressure) hold_req = 1;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            // Mostly short sets; now and then one that overflows the table.
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8);
            blank = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                c.candidate_id = $urandom;
                c.flow_known   = blank ? 1'b0 : ($urandom_range(0, 99) < 85);
                case ($urandom_range(0, 3))
                    0: c.flow_value = {14'd0, 2'($urandom_range(0, 3)), 8'd0};
                    1: c.flow_value = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0;
                    default: c.flow_value = 24'($urandom);
                endcase
                c.set_end = (k == len - 1);
                send_cand(c, 1'b0, NO_RES);
            end
            sent += len;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        row_typed     = 1'b0;
        row_res       = NO_RES;

        dir_rows = '{
            // Empty set straight after reset; the only candidate has no flow.
            '{ROW_CAND,  6'd0,  '{32'hFFFF_FFFF, 1'b0, 24'hFF_FFFF, 1'b1}, 1'b1, EMPTY_RES},
            '{ROW_CAND,  6'd0,  '{32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF, 1'b1}, 1'b1,
              '{32'hFFFF_FFFF, 24'hFF_FFFF, 5'd0, 1'b1, 1'b0}},
            '{ROW_CAND,  6'd0,  '{32'h0000_0000, 1'b1, 24'h00_0000, 1'b1}, 1'b1,
              '{32'h0000_0000, 24'h00_0000, 5'd0, 1'b1, 1'b0}},
            // Equal flows keep arrival order; an unknown flow is dropped.
            '{ROW_CAND,  6'd0,  '{32'h0000_00A1, 1'b1, 24'h00_0100, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_00B2, 1'b1, 24'h00_0100, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_00C3, 1'b1, 24'h00_0200, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_00D4, 1'b1, 24'h00_0000, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_00E5, 1'b0, 24'hFF_FFFF, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_00F6, 1'b1, 24'h00_0100, 1'b1}, 1'b0, NO_RES},
            // A zero limit drops everything and the set end gives the empty result.
            '{ROW_LIMIT, 6'd0,  '0, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h1234_5678, 1'b1, 24'h00_0005, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h8765_4321, 1'b1, 24'hFF_FFFF, 1'b1}, 1'b1, EMPTY_RES},
            // Candidates ranked past a limit of two are dropped, ties at the limit too.
            '{ROW_LIMIT, 6'd2,  '0, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0011, 1'b1, 24'h00_000A, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0022, 1'b1, 24'h00_0014, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0033, 1'b1, 24'h00_001E, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0044, 1'b1, 24'h00_0005, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0055, 1'b1, 24'h00_0014, 1'b1}, 1'b0, NO_RES},
            // Fill four entries, then lower the limit in mid-set and insert once more.
            '{ROW_LIMIT, 6'd4,  '0, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0061, 1'b1, 24'h00_0028, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0062, 1'b1, 24'h00_001E, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0063, 1'b1, 24'h00_0014, 1'b0}, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0064, 1'b1, 24'h00_000A, 1'b0}, 1'b0, NO_RES},
            '{ROW_LIMIT, 6'd2,  '0, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'h0000_0065, 1'b1, 24'h00_0023, 1'b1}, 1'b0, NO_RES},
            // A limit above the table depth acts as the depth.
            '{ROW_LIMIT, 6'd63, '0, 1'b0, NO_RES},
            '{ROW_CAND,  6'd0,  '{32'hA5A5_5A5A, 1'b1, 24'h00_8000, 1'b1}, 1'b1,
              '{32'hA5A5_5A5A, 24'h00_8000, 5'd0, 1'b1, 1'b0}},
            '{ROW_LIMIT, 6'd32, '0, 1'b0, NO_RES}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_LIMIT) begin
                write_limit(dir_rows[r].limit);
            end else begin
                send_cand(dir_rows[r].cand, dir_rows[r].typed, dir_rows[r].res);
            end
        end

        run_phase(6'd32, 0, 0, 1'b0);
        run_phase(6'd1, 75, 0, 1'b0);
        run_phase(6'd63, 0, 75, 1'b0);
        run_phase(CFG_W'($urandom_range(0, 63)), 13, 13, 1'b0);
        // The receiver holds off while the sender keeps offering, so the input stalls.
        run_phase(6'd8, 0, 0, 1'b1);

        i_in_valid <= 1'b0;
        while (ranked_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d candidates in %0d sets; %0d results checked, %0d of them empty.",
                 num_cands, num_sets, num_checked, num_empty);
        $display("Limits covered 0, 1, 2, 4, 8, 32 and 63, with idle and stall phases.");
        if (num_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
